// ===== design/tlvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types, codes and helpers for the IPv6 TLV options header parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned HDR_LEFT_W = 11;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [BYTE_W-1:0] PAD1_CODE_DEFAULT = 8'd0;
   localparam logic [BYTE_W-1:0] PADN_CODE_DEFAULT = 8'd1;
   localparam logic [BYTE_W-1:0] HOME_CODE_DEFAULT = 8'd201;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAD1_CODE = 2'd0,
      CSR_PADN_CODE = 2'd1,
      CSR_HOME_CODE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ROLE_NEXT_HDR = 3'd0,
      ROLE_EXT_LEN  = 3'd1,
      ROLE_OPT_TYPE = 3'd2,
      ROLE_OPT_LEN  = 3'd3,
      ROLE_OPT_DATA = 3'd4,
      ROLE_PAD1     = 3'd5
   } role_type;

   typedef enum logic [1:0] {
      CLASS_PAD1  = 2'd0,
      CLASS_PADN  = 2'd1,
      CLASS_HOME  = 2'd2,
      CLASS_OTHER = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      PH_NEXT_HDR = 3'd0,
      PH_EXT_LEN  = 3'd1,
      PH_OPT_TYPE = 3'd2,
      PH_OPT_LEN  = 3'd3,
      PH_OPT_DATA = 3'd4
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pad1_code;
      logic [BYTE_W-1:0] padn_code;
      logic [BYTE_W-1:0] home_code;
   } cfg_type;

   typedef struct packed {
      role_type          role;
      class_type         cls;
      logic [BYTE_W-1:0] code;
      logic [BYTE_W-1:0] didx;
      logic [BYTE_W-1:0] value;
      logic              opt_end;
      logic              hdr_end;
      logic              overrun;
   } result_type;

   function automatic class_type class_of(input logic [BYTE_W-1:0] code,
                                          input cfg_type cfg);
      class_type cls;
      if (code == cfg.pad1_code) begin
         cls = CLASS_PAD1;
      end else if (code == cfg.padn_code) begin
         cls = CLASS_PADN;
      end else if (code == cfg.home_code) begin
         cls = CLASS_HOME;
      end else begin
         cls = CLASS_OTHER;
      end
      return cls;
   endfunction

endpackage

// ===== design/tlvp_csr.sv =====
// ----------------------------------------------------------------------------
// tlvp_csr
// Option type code registers, written through the csr channel.
// ----------------------------------------------------------------------------
module tlvp_csr
   import tlvp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAD1_CODE: cfg_in.pad1_code = csr_data;
            CSR_PADN_CODE: cfg_in.padn_code = csr_data;
            CSR_HOME_CODE: cfg_in.home_code = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad1_code <= PAD1_CODE_DEFAULT;
         cfg_ff.padn_code <= PADN_CODE_DEFAULT;
         cfg_ff.home_code <= HOME_CODE_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/tlvp_parse.sv =====
// ----------------------------------------------------------------------------
// tlvp_parse
// Parser state and per-byte tagging of the options header stream.
// ----------------------------------------------------------------------------
module tlvp_parse
   import tlvp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              advance,
   input  logic [BYTE_W-1:0] data_byte,
   output result_type        result
);

   phase_type               phase_ff, phase_in;
   logic [HDR_LEFT_W-1:0]   hbl_ff, hbl_in, hbl_dec;
   logic [BYTE_W-1:0]       cur_ff, cur_in;
   logic [BYTE_W-1:0]       obl_ff, obl_in, obl_dec;
   logic [BYTE_W-1:0]       dpos_ff, dpos_in;
   logic                    ovr_ff, ovr_in;
   logic                    in_opts;

   assign obl_dec = obl_ff - 8'd1;

   always_comb begin
      phase_in = phase_ff;
      hbl_in   = hbl_ff;
      cur_in   = cur_ff;
      obl_in   = obl_ff;
      dpos_in  = dpos_ff;
      ovr_in   = ovr_ff;
      in_opts  = 1'b0;
      hbl_dec  = hbl_ff;
      result   = '0;
      result.role  = ROLE_NEXT_HDR;
      result.cls   = CLASS_PAD1;
      result.value = data_byte;

      unique case (phase_ff)
         PH_EXT_LEN: begin
            result.role = ROLE_EXT_LEN;
            hbl_in      = {data_byte, 3'b000} + HDR_LEFT_W'(6);
            phase_in    = PH_OPT_TYPE;
         end
         PH_OPT_TYPE: begin
            in_opts     = 1'b1;
            result.code = data_byte;
            result.cls  = class_of(data_byte, cfg);
            if (result.cls == CLASS_PAD1) begin
               result.role    = ROLE_PAD1;
               result.opt_end = 1'b1;
            end else begin
               result.role = ROLE_OPT_TYPE;
               cur_in      = data_byte;
               phase_in    = PH_OPT_LEN;
            end
         end
         PH_OPT_LEN: begin
            in_opts     = 1'b1;
            result.role = ROLE_OPT_LEN;
            result.code = cur_ff;
            result.cls  = class_of(cur_ff, cfg);
            obl_in      = data_byte;
            dpos_in     = '0;
            if (data_byte == '0) begin
               result.opt_end = 1'b1;
               phase_in       = PH_OPT_TYPE;
            end else begin
               phase_in = PH_OPT_DATA;
            end
         end
         PH_OPT_DATA: begin
            in_opts     = 1'b1;
            result.role = ROLE_OPT_DATA;
            result.code = cur_ff;
            result.cls  = class_of(cur_ff, cfg);
            result.didx = dpos_ff;
            dpos_in     = dpos_ff + 8'd1;
            obl_in      = obl_dec;
            if (obl_dec == '0) begin
               result.opt_end = 1'b1;
               phase_in       = PH_OPT_TYPE;
            end
         end
         default: begin
            result.role = ROLE_NEXT_HDR;
            ovr_in      = 1'b0;
            phase_in    = PH_EXT_LEN;
         end
      endcase

      if (in_opts) begin
         hbl_dec = (hbl_ff != '0) ? hbl_ff - HDR_LEFT_W'(1) : hbl_ff;
         hbl_in  = hbl_dec;
         if (hbl_dec == '0) begin
            result.hdr_end = 1'b1;
            if (phase_in != PH_OPT_TYPE) begin
               ovr_in         = 1'b1;
               result.opt_end = 1'b0;
            end
            phase_in = PH_NEXT_HDR;
         end
      end

      result.overrun = ovr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NEXT_HDR;
         hbl_ff   <= '0;
         cur_ff   <= '0;
         obl_ff   <= '0;
         dpos_ff  <= '0;
         ovr_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         hbl_ff   <= hbl_in;
         cur_ff   <= cur_in;
         obl_ff   <= obl_in;
         dpos_ff  <= dpos_in;
         ovr_ff   <= ovr_in;
      end
   end

endmodule

// ===== design/ipv6_tlv_options_header_parser.sv =====
// ----------------------------------------------------------------------------
// ipv6_tlv_options_header_parser
// Tags each byte of a hop-by-hop or destination options header.
//
// The req channel carries one header byte per transfer (req_valid/req_stall).
// Each byte yields one tagged result on the rsp channel (rsp_valid/rsp_stall):
// its role, option class and code, data index, option and header end marks,
// and the sticky overrun flag. Option type codes for Pad1, PadN and home
// address live in three registers written through csr_valid/csr_ready; write
// them only while no transfer is in flight.
// A byte is held in an input register, tagged by the parser, and registered
// in the result register. One byte is accepted every cycle while the output
// is not stalled; the phase and byte counters are updated from each byte as
// it leaves the input register, which sustains that rate.
// Reset empties both registers, clears the parser state (next byte is a
// next-header byte) and restores the default codes. While rsp_stall is high
// the result holds, the input register keeps one more byte, and req_stall
// then rises.
// ----------------------------------------------------------------------------
module ipv6_tlv_options_header_parser
   import tlvp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_byte_role,
   output logic [1:0]           rsp_option_class,
   output logic [7:0]           rsp_option_code,
   output logic [7:0]           rsp_data_index,
   output logic [7:0]           rsp_value,
   output logic                 rsp_option_end,
   output logic                 rsp_header_end,
   output logic                 rsp_overrun,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   cfg_type           cfg;
   result_type        result;
   result_type        rsp_ff;
   logic              in_full_ff, in_full_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_full_ff, out_full_in;
   logic              out_stall;
   logic              advance;
   logic              req_take;

   tlvp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tlvp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   assign out_stall = out_full_ff && rsp_stall;
   assign advance   = in_full_ff && !out_stall;
   assign req_stall = in_full_ff && out_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_full_in = 1'b1;
      end else if (advance) begin
         in_full_in = 1'b0;
      end else begin
         in_full_in = in_full_ff;
      end
      out_full_in = advance || out_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff  <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         in_full_ff  <= in_full_in;
         out_full_ff <= out_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = out_full_ff;
   assign rsp_byte_role    = rsp_ff.role;
   assign rsp_option_class = rsp_ff.cls;
   assign rsp_option_code  = rsp_ff.code;
   assign rsp_data_index   = rsp_ff.didx;
   assign rsp_value        = rsp_ff.value;
   assign rsp_option_end   = rsp_ff.opt_end;
   assign rsp_header_end   = rsp_ff.hdr_end;
   assign rsp_overrun      = rsp_ff.overrun;

   a_next_hdr_clears_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_NEXT_HDR) |-> !rsp_overrun && !rsp_header_end)
      else $error("overrun or header end on next-header byte");

   a_pad1_ends_option: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_role == ROLE_PAD1) |-> rsp_option_end
         && (rsp_option_class == CLASS_PAD1) && (rsp_option_code == rsp_value))
      else $error("pad1 byte not tagged as complete pad1 option");

   a_index_only_on_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data_index != '0) |-> (rsp_byte_role == ROLE_OPT_DATA))
      else $error("data index set on a non-data byte");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_full_ff && out_full_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule
